// ===== design/mfb_pkg.sv =====
// Shared types and codes for the monochrome shadow framebuffer rectangle unit.
// No dependencies; used by mfb_seq and the top level.

package mfb_pkg;

	// Action codes carried on the action port
	localparam logic [2:0] ACT_DRAW   = 3'd0;
	localparam logic [2:0] ACT_FILL   = 3'd1;
	localparam logic [2:0] ACT_INVERT = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// Configuration register indexes
	localparam logic [7:0] CFG_FRAME_WIDTH  = 8'd0;
	localparam logic [7:0] CFG_FRAME_HEIGHT = 8'd1;

	// Reset values of the configuration registers
	localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
	localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

	localparam int unsigned TOUCH_W = 14;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_ADDR,
		S_FILL,
		S_INV_RD,
		S_INV_WR,
		S_RD_ISSUE,
		S_RD_TAKE,
		S_DONE
	} mfb_state_t;

	// Result beat handed from the sequencer to the top level
	typedef struct packed {
		logic               done;
		logic               read_value;
		logic [TOUCH_W-1:0] touched;
	} mfb_result_t;

endpackage

// ===== design/mono_shadow_framebuffer_rect_ops_unit.sv =====
// Top level of the monochrome shadow framebuffer rectangle unit: size registers,
// active frame clamp, sequencer and frame store. Depends on mfb_pkg, mfb_seq, mfb_store.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------------
//  command   | start / busy               | action, pos_x, pos_y, rect_width, rect_height,
//            |                            | pixel_on
//  result    | done (one-cycle strobe)    | read_value, pixels_touched
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A command beat is taken when start is high and busy low. Fill and clear write each
// clipped pixel in turn, invert reads then writes each one on the single store port,
// a read issues one store read, a clipped or unknown action goes straight to done;
// the store port sets the pace. After reset and after any size-changing write, busy
// stays high while all MAX_WIDTH * MAX_HEIGHT pixels are cleared. Results are shown
// for one cycle under done; the receiver cannot stall. cfg_ready is always high.

module mono_shadow_framebuffer_rect_ops_unit #(
	parameter int unsigned MAX_WIDTH  = 128,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    action,
	input  logic [15:0]                   pos_x,
	input  logic [15:0]                   pos_y,
	input  logic [15:0]                   rect_width,
	input  logic [15:0]                   rect_height,
	input  logic                          pixel_on,
	output logic                          done,
	output logic                          read_value,
	output logic [mfb_pkg::TOUCH_W-1:0]   pixels_touched,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);

	localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [7:0]           frame_width_q;
	logic [6:0]           frame_height_q;
	logic                 cfg_wr, width_chg, height_chg, clear_req;
	logic [XW-1:0]        fw;
	logic [YW-1:0]        fh;
	logic                 mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0]        mem_addr;
	mfb_pkg::mfb_result_t res;

	// configuration writes; a changed size clears the store
	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign width_chg  = cfg_wr && (cfg_index == mfb_pkg::CFG_FRAME_WIDTH)
	                    && (cfg_data != frame_width_q);
	assign height_chg = cfg_wr && (cfg_index == mfb_pkg::CFG_FRAME_HEIGHT)
	                    && (cfg_data[6:0] != frame_height_q);
	assign clear_req  = width_chg || height_chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mfb_pkg::FRAME_WIDTH_RST;
			frame_height_q <= mfb_pkg::FRAME_HEIGHT_RST;
		end else begin
			if (width_chg) begin
				frame_width_q <= cfg_data;
			end
			if (height_chg) begin
				frame_height_q <= cfg_data[6:0];
			end
		end
	end

	// active frame, capped at the store size
	assign fw = (16'(frame_width_q) > 16'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(frame_width_q);
	assign fh = (16'(frame_height_q) > 16'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
	                                                     : YW'(frame_height_q);

	mfb_seq #(
		.XW    (XW),
		.YW    (YW),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.pixel_on    (pixel_on),
		.fw          (fw),
		.fh          (fh),
		.clear_req   (clear_req),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.res         (res)
	);

	mfb_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// result beat
	assign done           = res.done;
	assign read_value     = res.read_value;
	assign pixels_touched = res.touched;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command beat taken but unit not busy");

	a_read_no_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_value) |-> (pixels_touched == '0))
		else $error("read result reports touched pixels");

	a_resize_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clear_req |=> busy)
		else $error("size change did not start clearing pass");
`endif

endmodule

// ===== design/mfb_store.sv =====
// One-bit-per-pixel frame store: single address, synchronous write, registered read.
// No dependencies.

module mfb_store #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read of the same address
	always_ff @(posedge clk) begin
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mfb_seq.sv =====
// Sequencer for the framebuffer: clipping, start address, pixel walk and clearing pass.
// Depends on mfb_pkg; drives the mfb_store port.

module mfb_seq #(
	parameter int unsigned XW    = 8,
	parameter int unsigned YW    = 7,
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           action,
	input  logic [15:0]          pos_x,
	input  logic [15:0]          pos_y,
	input  logic [15:0]          rect_width,
	input  logic [15:0]          rect_height,
	input  logic                 pixel_on,
	input  logic [XW-1:0]        fw,
	input  logic [YW-1:0]        fh,
	input  logic                 clear_req,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_addr,
	output logic                 mem_wdata,
	input  logic                 mem_rdata,
	output mfb_pkg::mfb_result_t res
);

	localparam int unsigned PW = XW + YW;

	mfb_pkg::mfb_state_t state_q, state_d;

	logic [2:0]                  op_q;
	logic                        val_q;
	logic [XW-1:0]               x0_q, xe_q, xx_q;
	logic [YW-1:0]               y_q, ye_q;
	logic [AW-1:0]               prod_q, stride_q, addr_q;
	logic [mfb_pkg::TOUCH_W-1:0] cnt_q;
	logic                        rd_q;

	logic [15:0]   eff_x, eff_y, eff_w, eff_h;
	logic [16:0]   x_end, y_end;
	logic [XW-1:0] xe_clip;
	logic [YW-1:0] ye_clip;
	logic          in_frame, nonempty;
	logic [XW-1:0] xx_nxt;
	logic [YW-1:0] y_nxt;
	logic          col_last, row_last;
	logic [PW-1:0] prod;
	logic [AW-1:0] add_a, add_b, add_sum;

	// operands of the item as the action sees them
	always_comb begin
		eff_x = pos_x;
		eff_y = pos_y;
		eff_w = rect_width;
		eff_h = rect_height;
		unique case (action) inside
			mfb_pkg::ACT_DRAW: begin
				eff_w = 16'd1;
				eff_h = 16'd1;
			end
			mfb_pkg::ACT_CLEAR: begin
				eff_x = '0;
				eff_y = '0;
				eff_w = 16'(fw);
				eff_h = 16'(fh);
			end
			default: begin
			end
		endcase
	end

	// clip to the active frame: cut at right and bottom edges
	assign x_end    = {1'b0, eff_x} + {1'b0, eff_w};
	assign y_end    = {1'b0, eff_y} + {1'b0, eff_h};
	assign xe_clip  = (x_end > 17'(fw)) ? fw : XW'(x_end);
	assign ye_clip  = (y_end > 17'(fh)) ? fh : YW'(y_end);
	assign in_frame = (eff_x < 16'(fw)) && (eff_y < 16'(fh));
	assign nonempty = in_frame && (eff_w != '0) && (eff_h != '0);

	// walk position
	assign xx_nxt   = xx_q + XW'(1);
	assign y_nxt    = y_q + YW'(1);
	assign col_last = (xx_nxt == xe_q);
	assign row_last = (y_nxt == ye_q);

	// row start offset
	assign prod = PW'(y_q) * PW'(fw);

	// shared address adder
	always_comb begin
		add_a = addr_q;
		add_b = '0;
		unique case (state_q) inside
			mfb_pkg::S_CLEAR: begin
				add_b = AW'(1);
			end
			mfb_pkg::S_ADDR: begin
				add_a = prod_q;
				add_b = AW'(x0_q);
			end
			mfb_pkg::S_FILL, mfb_pkg::S_INV_WR: begin
				add_b = col_last ? stride_q : AW'(1);
			end
			default: begin
			end
		endcase
	end
	assign add_sum = add_a + add_b;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfb_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		unique case (state_q)
			mfb_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == AW'(DEPTH - 1)) begin
					state_d = mfb_pkg::S_IDLE;
				end
			end
			mfb_pkg::S_IDLE: begin
				if (start) begin
					unique case (action) inside
						mfb_pkg::ACT_DRAW, mfb_pkg::ACT_FILL,
						mfb_pkg::ACT_INVERT, mfb_pkg::ACT_CLEAR: begin
							state_d = nonempty ? mfb_pkg::S_SETUP : mfb_pkg::S_DONE;
						end
						mfb_pkg::ACT_READ: begin
							state_d = in_frame ? mfb_pkg::S_SETUP : mfb_pkg::S_DONE;
						end
						default: begin
							state_d = mfb_pkg::S_DONE;
						end
					endcase
				end
			end
			mfb_pkg::S_SETUP: begin
				state_d = mfb_pkg::S_ADDR;
			end
			mfb_pkg::S_ADDR: begin
				unique case (op_q) inside
					mfb_pkg::ACT_READ:   state_d = mfb_pkg::S_RD_ISSUE;
					mfb_pkg::ACT_INVERT: state_d = mfb_pkg::S_INV_RD;
					default:             state_d = mfb_pkg::S_FILL;
				endcase
			end
			mfb_pkg::S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
				if (col_last && row_last) begin
					state_d = mfb_pkg::S_DONE;
				end
			end
			mfb_pkg::S_INV_RD: begin
				state_d = mfb_pkg::S_INV_WR;
			end
			mfb_pkg::S_INV_WR: begin
				mem_we    = 1'b1;
				mem_wdata = ~mem_rdata;
				state_d   = (col_last && row_last) ? mfb_pkg::S_DONE : mfb_pkg::S_INV_RD;
			end
			mfb_pkg::S_RD_ISSUE: begin
				state_d = mfb_pkg::S_RD_TAKE;
			end
			mfb_pkg::S_RD_TAKE: begin
				state_d = mfb_pkg::S_DONE;
			end
			mfb_pkg::S_DONE: begin
				state_d = mfb_pkg::S_IDLE;
			end
			default: begin
				state_d = mfb_pkg::S_IDLE;
			end
		endcase
		// a size change restarts the clearing pass
		if (clear_req) begin
			state_d = mfb_pkg::S_CLEAR;
		end
	end

	// address register: part of the clearing pass, so reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (clear_req) begin
			addr_q <= '0;
		end else begin
			case (state_q) inside
				mfb_pkg::S_CLEAR, mfb_pkg::S_ADDR,
				mfb_pkg::S_FILL, mfb_pkg::S_INV_WR: begin
					addr_q <= add_sum;
				end
				default: begin
				end
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q) inside
			mfb_pkg::S_IDLE: begin
				if (start) begin
					op_q  <= action;
					val_q <= pixel_on;
					x0_q  <= XW'(eff_x);
					xx_q  <= XW'(eff_x);
					xe_q  <= xe_clip;
					y_q   <= YW'(eff_y);
					ye_q  <= ye_clip;
					cnt_q <= '0;
					rd_q  <= 1'b0;
				end
			end
			mfb_pkg::S_SETUP: begin
				prod_q   <= AW'(prod);
				// jump from last column of one row to first of the next
				stride_q <= AW'(fw) - AW'(xe_q) + AW'(x0_q) + AW'(1);
			end
			mfb_pkg::S_FILL, mfb_pkg::S_INV_WR: begin
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + mfb_pkg::TOUCH_W'(1);
				end
				if (col_last) begin
					xx_q <= x0_q;
					y_q  <= y_nxt;
				end else begin
					xx_q <= xx_nxt;
				end
			end
			mfb_pkg::S_RD_TAKE: begin
				rd_q <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

	assign mem_addr       = addr_q;
	assign busy           = (state_q != mfb_pkg::S_IDLE);
	assign res.done       = (state_q == mfb_pkg::S_DONE);
	assign res.read_value = rd_q;
	assign res.touched    = cnt_q;

endmodule
